>>> rtl/smt_pkg.sv
// Shared constants, types and width helpers for the sphericity tensor block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package smt_pkg;

    // Fixed field widths of the jet and tensor items
    localparam int JET_W  = 16;
    localparam int T_W    = 17;
    localparam int Q_BITS = 16;

    // Defaults for the top level parameters
    localparam int DEF_MAX_JETS      = 16;
    localparam int DEF_MOMENTUM_BITS = 16;

    // Entries in the event queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Number of tensor elements worked out per event
    localparam int N_LANES = 6;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Width of one diagonal sum: a full square times the jet limit
    function automatic int diag_w(input int mom_bits, input int max_jets);
        return 2 * mom_bits - 2 + $clog2(max_jets) + 1;
    endfunction

    // Width of one finished event record: three diagonal sums, three signed
    // cross sums and the overflow flag
    function automatic int rec_w(input int mom_bits, input int max_jets);
        return 3 * diag_w(mom_bits, max_jets) + 3 * (diag_w(mom_bits, max_jets) + 1) + 1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/smt_if.sv
// Handshake interfaces for jet items in and tensor items out.
// Depends on smt_pkg for the field widths.
`default_nettype none

interface smt_jet_if
    import smt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [JET_W-1:0] jet_px;
    logic signed [JET_W-1:0] jet_py;
    logic signed [JET_W-1:0] jet_pz;
    logic                    last_jet;

    modport source (output valid, jet_px, jet_py, jet_pz, last_jet, input ready);
    modport sink   (input valid, jet_px, jet_py, jet_pz, last_jet, output ready);
endinterface

interface smt_tensor_if
    import smt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic        [T_W-1:0] t_xx;
    logic        [T_W-1:0] t_yy;
    logic        [T_W-1:0] t_zz;
    logic signed [T_W-1:0] t_xy;
    logic signed [T_W-1:0] t_xz;
    logic signed [T_W-1:0] t_yz;
    logic                  too_many_jets;

    modport source (output valid, t_xx, t_yy, t_zz, t_xy, t_xz, t_yz, too_many_jets,
                    input ready);
    modport sink   (input valid, t_xx, t_yy, t_zz, t_xy, t_xz, t_yz, too_many_jets,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/smt_front.sv
// Front end: accepts jets, forms the component products and accumulates the sums.
// Depends on smt_pkg and smt_jet_if; pushes one record per event into smt_queue.
`default_nettype none

module smt_front
    import smt_pkg::*;
#(
    parameter int MAX_JETS      = DEF_MAX_JETS,
    parameter int MOMENTUM_BITS = DEF_MOMENTUM_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    smt_jet_if.sink                      jet,
    output logic                         push,
    output logic [rec_w(MOMENTUM_BITS, MAX_JETS)-1:0] push_data,
    input  q_status_t                    q_stat
);

    localparam int M   = MOMENTUM_BITS;
    localparam int DW  = diag_w(MOMENTUM_BITS, MAX_JETS);
    localparam int OW  = DW + 1;
    localparam int CW  = $clog2(MAX_JETS + 1);
    localparam int SQW = 2 * M - 1;
    localparam int XW  = 2 * M;

    // Jet bookkeeping for the event being accepted
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          keep;
    logic          fire;

    // Product stage
    logic                  a_valid_reg;
    logic                  a_last_reg;
    logic                  a_ovf_reg;
    logic        [SQW-1:0] sq_reg   [3];
    logic signed [XW-1:0]  cross_reg[3];
    logic                  a_go;

    // Running sums
    logic        [DW-1:0] sd_reg   [3];
    logic signed [OW-1:0] so_reg   [3];
    logic        [DW-1:0] sd_next  [3];
    logic signed [OW-1:0] so_next  [3];

    logic        [31:0]   raw_px, raw_py, raw_pz;
    logic signed [M-1:0]  px, py, pz;
    logic signed [XW-1:0] pxx, pyy, pzz, pxy, pxz, pyz;

    // Take the low MOMENTUM_BITS of each field and sign extend from there
    assign raw_px = 32'($unsigned(jet.jet_px));
    assign raw_py = 32'($unsigned(jet.jet_py));
    assign raw_pz = 32'($unsigned(jet.jet_pz));
    assign px     = $signed(raw_px[M-1:0]);
    assign py     = $signed(raw_py[M-1:0]);
    assign pz     = $signed(raw_pz[M-1:0]);

    assign pxx = XW'(px) * XW'(px);
    assign pyy = XW'(py) * XW'(py);
    assign pzz = XW'(pz) * XW'(pz);
    assign pxy = XW'(px) * XW'(py);
    assign pxz = XW'(px) * XW'(pz);
    assign pyz = XW'(py) * XW'(pz);

    // Stall the product stage only on an event close with the queue full
    assign a_go      = !a_last_reg || !q_stat.full;
    assign jet.ready = !a_valid_reg || a_go;
    assign fire      = jet.valid && jet.ready;

    assign keep     = (count_reg != CW'(MAX_JETS));
    assign ovf_next = ovf_reg | ~keep;

    always_comb
    begin
        count_next = count_reg;
        if (keep)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // Count jets and note dropped ones
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (jet.last_jet)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Register the products; a dropped jet contributes zeros
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            a_ovf_reg   <= 1'b0;
        end
        else if (fire)
        begin
            a_valid_reg <= 1'b1;
            a_last_reg  <= jet.last_jet;
            a_ovf_reg   <= ovf_next;
        end
        else if (a_go)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sq_reg[0]    <= keep ? pxx[SQW-1:0] : '0;
            sq_reg[1]    <= keep ? pyy[SQW-1:0] : '0;
            sq_reg[2]    <= keep ? pzz[SQW-1:0] : '0;
            cross_reg[0] <= keep ? pxy : '0;
            cross_reg[1] <= keep ? pxz : '0;
            cross_reg[2] <= keep ? pyz : '0;
        end
    end

    // Add the products to the sums
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sd_next[i] = sd_reg[i] + DW'(sq_reg[i]);
            so_next[i] = so_reg[i] + OW'(cross_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sd_reg[i] <= '0;
                so_reg[i] <= '0;
            end
        end
        else if (a_valid_reg && a_go)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sd_reg[i] <= a_last_reg ? '0 : sd_next[i];
                so_reg[i] <= a_last_reg ? '0 : so_next[i];
            end
        end
    end

    // Close the event: hand the final sums to the queue
    assign push      = a_valid_reg && a_last_reg && !q_stat.full;
    assign push_data = {a_ovf_reg, so_next[2], so_next[1], so_next[0],
                        sd_next[2], sd_next[1], sd_next[0]};

endmodule

`default_nettype wire

>>> rtl/smt_queue.sv
// Short register queue carrying finished event records from front to back.
// Depends on smt_pkg for the status struct.
`default_nettype none

module smt_queue
    import smt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head_data,
    output q_status_t             q_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign head_data    = mem_reg[rd_ptr_reg];
    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == CW'(DEPTH));

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    // Store the record
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/smt_back.sv
// Back end: six restoring dividers normalise an event's sums by the momentum total.
// Depends on smt_pkg and smt_tensor_if; takes records from smt_queue.
`default_nettype none

module smt_back
    import smt_pkg::*;
#(
    parameter int MAX_JETS      = DEF_MAX_JETS,
    parameter int MOMENTUM_BITS = DEF_MOMENTUM_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [rec_w(MOMENTUM_BITS, MAX_JETS)-1:0] head_data,
    input  q_status_t                    q_stat,
    output logic                         pop,
    smt_tensor_if.source                 tensor
);

    localparam int DW = diag_w(MOMENTUM_BITS, MAX_JETS);
    localparam int OW = DW + 1;
    localparam int PW = DW + 2;
    localparam int RW = PW + 1;
    localparam int SW = $clog2(T_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t state_reg;

    logic [SW-1:0]  step_reg;
    logic [PW-1:0]  den_reg;
    logic [RW-1:0]  rem_reg [N_LANES];
    logic [T_W-1:0] quo_reg [N_LANES];
    logic           neg_reg [N_LANES];
    logic           ovf_reg;

    // Output register
    logic           out_valid_reg;
    logic [T_W-1:0] t_reg [N_LANES];
    logic           tmj_reg;

    // Record fields
    logic        [DW-1:0] hd [3];
    logic signed [OW-1:0] ho [3];
    logic                 h_ovf;
    logic        [PW-1:0] den_load;
    logic        [PW-1:0] num_load [N_LANES];
    logic                 neg_load [N_LANES];

    // Divider step per lane
    logic [RW-1:0]  rs   [N_LANES];
    logic           ge   [N_LANES];
    logic [T_W-1:0] tval [N_LANES];
    logic           out_free;

    assign {h_ovf, ho[2], ho[1], ho[0], hd[2], hd[1], hd[0]} = head_data;

    // Unpack the record into per-lane magnitudes and signs
    always_comb
    begin
        den_load = PW'(hd[0]) + PW'(hd[1]) + PW'(hd[2]);
        for (int i = 0; i < 3; i++)
        begin
            num_load[i]     = PW'(hd[i]);
            neg_load[i]     = 1'b0;
            neg_load[i + 3] = ho[i][OW-1];
            num_load[i + 3] = PW'(ho[i][OW-1] ? $unsigned(-ho[i]) : $unsigned(ho[i]));
        end
    end

    // One quotient bit per lane per cycle; the first step takes the integer bit
    always_comb
    begin
        for (int i = 0; i < N_LANES; i++)
        begin
            rs[i] = (step_reg == '0) ? rem_reg[i] : {rem_reg[i][RW-2:0], 1'b0};
            ge[i] = (rs[i] >= RW'(den_reg));
        end
    end

    // Restore sign and force zeros on a zero total
    always_comb
    begin
        for (int i = 0; i < N_LANES; i++)
        begin
            if (den_reg == '0)
            begin
                tval[i] = '0;
            end
            else if (neg_reg[i])
            begin
                tval[i] = -quo_reg[i];
            end
            else
            begin
                tval[i] = quo_reg[i];
            end
        end
    end

    assign out_free = !out_valid_reg || tensor.ready;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;

    // Sequence load, divide and hand-off, and hold the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_HOLD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tensor.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == SW'(T_W - 1))
                    begin
                        state_reg <= ST_HOLD;
                    end
                    else
                    begin
                        step_reg <= step_reg + SW'(1);
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Divider datapath and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            den_reg <= den_load;
            ovf_reg <= h_ovf;
            for (int i = 0; i < N_LANES; i++)
            begin
                rem_reg[i] <= RW'(num_load[i]);
                quo_reg[i] <= '0;
                neg_reg[i] <= neg_load[i];
            end
        end
        else if (state_reg == ST_DIV)
        begin
            for (int i = 0; i < N_LANES; i++)
            begin
                rem_reg[i] <= ge[i] ? rs[i] - RW'(den_reg) : rs[i];
                quo_reg[i] <= {quo_reg[i][T_W-2:0], ge[i]};
            end
        end
        if ((state_reg == ST_HOLD) && out_free)
        begin
            for (int i = 0; i < N_LANES; i++)
            begin
                t_reg[i] <= tval[i];
            end
            tmj_reg <= ovf_reg;
        end
    end

    assign tensor.valid         = out_valid_reg;
    assign tensor.t_xx          = t_reg[0];
    assign tensor.t_yy          = t_reg[1];
    assign tensor.t_zz          = t_reg[2];
    assign tensor.t_xy          = $signed(t_reg[3]);
    assign tensor.t_xz          = $signed(t_reg[4]);
    assign tensor.t_yz          = $signed(t_reg[5]);
    assign tensor.too_many_jets = tmj_reg;

endmodule

`default_nettype wire

>>> rtl/sphericity_momentum_tensor_top.sv
// Top level of the sphericity momentum tensor block: front, event queue and back.
// Depends on smt_pkg, smt_if, smt_front, smt_queue and smt_back.
//
//   port     role    item                         stall
//   jet      sink    px, py, pz, last_jet         ready low while a close waits on a full queue
//   tensor   source  six Q.16 elements, drop flag valid held until ready
//
// Jets are taken one per cycle while no event close waits on a full queue. An
// event's result leaves the back end through one load, 17 divider steps
// (one quotient bit per cycle in six parallel lanes) and one hand-off into the output register.
// The queue holds two closed events, so the front stalls only when events
// close faster than the dividers drain. Reset clears all sums and counts.
`default_nettype none

module sphericity_momentum_tensor_top
    import smt_pkg::*;
#(
    parameter int MAX_JETS      = DEF_MAX_JETS,
    parameter int MOMENTUM_BITS = DEF_MOMENTUM_BITS
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    smt_jet_if.sink      jet,
    smt_tensor_if.source tensor
);

    localparam int RECW = rec_w(MOMENTUM_BITS, MAX_JETS);

    logic            q_push;
    logic            q_pop;
    logic [RECW-1:0] q_push_data;
    logic [RECW-1:0] q_head_data;
    q_status_t       q_stat;
    logic [T_W+1:0]  trace;

    smt_front #(
        .MAX_JETS      (MAX_JETS),
        .MOMENTUM_BITS (MOMENTUM_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .jet       (jet),
        .push      (q_push),
        .push_data (q_push_data),
        .q_stat    (q_stat)
    );

    smt_queue #(
        .WIDTH (RECW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head_data),
        .q_stat    (q_stat)
    );

    smt_back #(
        .MAX_JETS      (MAX_JETS),
        .MOMENTUM_BITS (MOMENTUM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_data (q_head_data),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .tensor    (tensor)
    );

    // Trace of the diagonal: each element loses under one unit to truncation
    assign trace = (T_W + 2)'(tensor.t_xx) + (T_W + 2)'(tensor.t_yy)
                 + (T_W + 2)'(tensor.t_zz);

    // Front never closes an event into a full queue
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("event record pushed into a full queue");

    // Back never takes a record that is not there
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("event record popped from an empty queue");

    // Normalised diagonal sums to one, less truncation, or is all zero
    a_trace: assert property (@(posedge clk) disable iff (!rst_n)
        tensor.valid |-> (trace == '0)
                      || ((trace <= (T_W + 2)'(1 << Q_BITS))
                          && (trace >= (T_W + 2)'((1 << Q_BITS) - 2))))
        else $error("tensor trace out of range");

endmodule

`default_nettype wire

>>> tb/tb_sphericity_momentum_tensor_top.sv
// Testbench for the sphericity momentum tensor block: jet items in, tensor items out.
// Depends on smt_pkg, smt_if and the sphericity_momentum_tensor_top RTL.
`timescale 1ns / 100ps

module tb_sphericity_momentum_tensor_top;
    import smt_pkg::*;

    localparam int MAX_JETS_TB  = DEF_MAX_JETS;
    localparam int MOM_BITS_TB  = DEF_MOMENTUM_BITS;
    localparam int RANDOM_JETS  = 1000;
    localparam int CALM_TAIL    = 100;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [JET_W-1:0] px;
        logic signed [JET_W-1:0] py;
        logic signed [JET_W-1:0] pz;
        logic                    last;
    } jet_item_t;

    typedef struct {
        logic [T_W-1:0] xx;
        logic [T_W-1:0] yy;
        logic [T_W-1:0] zz;
        logic [T_W-1:0] xy;
        logic [T_W-1:0] xz;
        logic [T_W-1:0] yz;
        logic           dropped;
    } tensor_item_t;

    logic clk;
    logic rst_n;

    smt_jet_if    jet_ch ();
    smt_tensor_if tensor_ch ();

    sphericity_momentum_tensor_top #(
        .MAX_JETS      (MAX_JETS_TB),
        .MOMENTUM_BITS (MOM_BITS_TB)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .jet    (jet_ch),
        .tensor (tensor_ch)
    );

    // Stimulus and expectation stores
    jet_item_t    jets_to_send[$];
    tensor_item_t tensor_due[$];

    // Running sums of the event being collected
    longint unsigned acc_diag[3];
    longint          acc_cross[3];
    longint unsigned acc_p2;
    int              jets_in_event;
    bit              jets_dropped;

    int  jets_queued;
    int  jets_taken;
    int  tensors_seen;
    int  events_closed;
    int  drop_events;
    int  zero_events;
    int  fail_count;
    bit  calm;
    bit  jet_fired;
    int  jet_gap;
    int  ready_hold;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sign extend a component from the momentum width
    function automatic longint mom_value(input logic [JET_W-1:0] raw);
        logic [63:0] w;
        w = 64'(raw) << (64 - MOM_BITS_TB);
        return $signed(w) >>> (64 - MOM_BITS_TB);
    endfunction

    // Q.16 ratio of a non-negative sum to the total, truncated
    function automatic logic [T_W-1:0] q16_ratio(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        q = (num << Q_BITS) / den;
        return q[T_W-1:0];
    endfunction

    // Q.16 ratio of a signed cross sum, truncated toward zero
    function automatic logic [T_W-1:0] q16_signed_ratio(input longint num,
                                                        input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag << Q_BITS) / den;
        if (num < 0)
            q = -q;
        return q[T_W-1:0];
    endfunction

    // Add one accepted jet to the event sums; close the event on the last jet
    task automatic accumulate_jet(input jet_item_t j);
        longint       p[3];
        tensor_item_t t;
        p[0] = mom_value(j.px);
        p[1] = mom_value(j.py);
        p[2] = mom_value(j.pz);
        if (jets_in_event < MAX_JETS_TB)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_diag[i] += longint'(p[i] * p[i]);
                acc_p2      += longint'(p[i] * p[i]);
            end
            acc_cross[0] += p[0] * p[1];
            acc_cross[1] += p[0] * p[2];
            acc_cross[2] += p[1] * p[2];
            jets_in_event++;
        end
        else
            jets_dropped = 1'b1;

        if (j.last)
        begin
            if (acc_p2 == 0)
            begin
                t.xx = '0; t.yy = '0; t.zz = '0;
                t.xy = '0; t.xz = '0; t.yz = '0;
                zero_events++;
            end
            else
            begin
                t.xx = q16_ratio(acc_diag[0], acc_p2);
                t.yy = q16_ratio(acc_diag[1], acc_p2);
                t.zz = q16_ratio(acc_diag[2], acc_p2);
                t.xy = q16_signed_ratio(acc_cross[0], acc_p2);
                t.xz = q16_signed_ratio(acc_cross[1], acc_p2);
                t.yz = q16_signed_ratio(acc_cross[2], acc_p2);
            end
            t.dropped = jets_dropped;
            if (jets_dropped)
                drop_events++;
            tensor_due.insert(tensor_due.size(), t);
            events_closed++;
            for (int i = 0; i < 3; i++)
            begin
                acc_diag[i]  = 0;
                acc_cross[i] = 0;
            end
            acc_p2        = 0;
            jets_in_event = 0;
            jets_dropped  = 1'b0;
        end
    endtask

    task automatic queue_jet(input logic [JET_W-1:0] px, input logic [JET_W-1:0] py,
                             input logic [JET_W-1:0] pz, input logic last);
        jet_item_t j;
        j.px = px;
        j.py = py;
        j.pz = pz;
        j.last = last;
        jets_to_send.insert(jets_to_send.size(), j);
        jets_queued++;
    endtask

    // One random component in the style chosen for the event
    function automatic logic [JET_W-1:0] pick_mom(input int style);
        logic [JET_W-1:0] v;
        case (style)
            0: v = JET_W'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: v = 16'h8000;
                    1: v = 16'h7fff;
                    2: v = 16'h0000;
                    3: v = 16'hffff;
                    default: v = 16'h0001;
                endcase
            end
            default: v = JET_W'(int'($urandom_range(0, 128)) - 64);
        endcase
        return v;
    endfunction

    task automatic check_field(input string name, input logic [T_W-1:0] exp_v,
                               input logic [T_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: tensor %0d field %s mismatch: expected %0h, got %0h",
                     $time, tensors_seen, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Sample handshakes at the rising edge: predict on jets, check tensors
    always @(posedge clk)
    begin
        jet_item_t    j;
        tensor_item_t t;
        jet_fired = jet_ch.valid && jet_ch.ready;
        if (jet_fired)
        begin
            j.px   = jet_ch.jet_px;
            j.py   = jet_ch.jet_py;
            j.pz   = jet_ch.jet_pz;
            j.last = jet_ch.last_jet;
            accumulate_jet(j);
            jets_taken++;
        end
        if (tensor_ch.valid && tensor_ch.ready)
        begin
            if (tensor_due.size() == 0)
            begin
                $display("%0t: tensor item with no event waiting: expected none, got %0h %0h %0h",
                         $time, tensor_ch.t_xx, tensor_ch.t_yy, tensor_ch.t_zz);
                fail_count++;
            end
            else
            begin
                t = tensor_due.pop_front();
                check_field("t_xx", t.xx, tensor_ch.t_xx);
                check_field("t_yy", t.yy, tensor_ch.t_yy);
                check_field("t_zz", t.zz, tensor_ch.t_zz);
                check_field("t_xy", t.xy, tensor_ch.t_xy);
                check_field("t_xz", t.xz, tensor_ch.t_xz);
                check_field("t_yz", t.yz, tensor_ch.t_yz);
                check_field("too_many_jets", T_W'(t.dropped), T_W'(tensor_ch.too_many_jets));
            end
            tensors_seen++;
        end
    end

    // Drive jets at the falling edge; hold the item until it is taken
    always @(negedge clk)
    begin
        jet_item_t j;
        if (rst_n && (!jet_ch.valid || jet_fired))
        begin
            if (jet_gap > 0)
            begin
                jet_gap--;
                jet_ch.valid <= 1'b0;
            end
            else if (jets_to_send.size() == 0)
                jet_ch.valid <= 1'b0;
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                jet_gap = $urandom_range(0, 9);
                jet_ch.valid <= 1'b0;
            end
            else
            begin
                j = jets_to_send.pop_front();
                jet_ch.jet_px   <= j.px;
                jet_ch.jet_py   <= j.py;
                jet_ch.jet_pz   <= j.pz;
                jet_ch.last_jet <= j.last;
                jet_ch.valid    <= 1'b1;
            end
        end
    end

    // Stall the tensor side in random bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_hold > 0)
            begin
                ready_hold--;
                tensor_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                ready_hold = $urandom_range(0, 9);
                tensor_ch.ready <= 1'b0;
            end
            else
                tensor_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb_sphericity_momentum_tensor_top NOT OK");
        $finish;
    end

    // Reset, directed events, pause, random events, drain
    initial
    begin
        int n;
        int style;
        bit zero_ev;
        rst_n              = 1'b0;
        jet_ch.valid       = 1'b0;
        jet_ch.jet_px      = '0;
        jet_ch.jet_py      = '0;
        jet_ch.jet_pz      = '0;
        jet_ch.last_jet    = 1'b0;
        tensor_ch.ready    = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc_diag[i]  = 0;
            acc_cross[i] = 0;
        end
        acc_p2        = 0;
        jets_in_event = 0;
        jets_dropped  = 1'b0;
        jets_queued   = 0;
        jets_taken    = 0;
        tensors_seen  = 0;
        events_closed = 0;
        drop_events   = 0;
        zero_events   = 0;
        fail_count    = 0;
        calm          = 1'b0;
        jet_fired     = 1'b0;
        jet_gap       = 0;
        ready_hold    = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty event sent as one zero jet: zero total
        queue_jet(16'h0000, 16'h0000, 16'h0000, 1'b1);
        // Pure x jet: full-scale diagonal element
        queue_jet(16'h7fff, 16'h0000, 16'h0000, 1'b1);
        // Most negative components on all axes
        queue_jet(16'h8000, 16'h8000, 16'h8000, 1'b1);
        // Opposite extremes: negative cross term, truncated toward zero
        queue_jet(16'h8000, 16'h7fff, 16'h0000, 1'b1);
        // Two-jet event with mixed signs
        queue_jet(16'd100, -16'sd200, 16'd300, 1'b0);
        queue_jet(-16'sd5, 16'd7, -16'sd11, 1'b1);
        // Smallest cross term reaching minus one half
        queue_jet(16'h0000, 16'hffff, 16'h0001, 1'b1);
        // Full jet limit of extremes, then a dropped jet carrying last_jet
        for (int i = 0; i <= MAX_JETS_TB; i++)
            queue_jet(16'h8000, (i % 2) ? 16'h7fff : 16'h8000, 16'h7fff,
                      i == MAX_JETS_TB);

        // Hold off the sender until every directed tensor has come back
        while (jets_taken != jets_queued || tensor_due.size() != 0)
            @(negedge clk);
        @(posedge clk);

        // Random events, mostly within the jet limit
        while (jets_queued < RANDOM_JETS + 25)
        begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(MAX_JETS_TB + 1, MAX_JETS_TB + 8);
                1: n = MAX_JETS_TB;
                default: n = $urandom_range(1, MAX_JETS_TB);
            endcase
            zero_ev = ($urandom_range(0, 19) == 0);
            style   = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
            begin
                if (zero_ev)
                    queue_jet('0, '0, '0, i == n - 1);
                else
                    queue_jet(pick_mom(style), pick_mom(style), pick_mom(style), i == n - 1);
            end
        end

        // No idling over the tail of the run
        while (jets_queued - jets_taken > CALM_TAIL)
            @(negedge clk);
        @(posedge clk);
        calm = 1'b1;

        // Drain, then wait on so that any stray tensor item is still checked
        while (jets_taken != jets_queued || tensor_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d jets in %0d events: %0d with dropped jets, %0d with zero total.",
                 jets_taken, events_closed, drop_events, zero_events);
        $display("Checked %0d tensor items, %0d field mismatches.", tensors_seen, fail_count);
        if (fail_count == 0 && tensor_due.size() == 0)
            $display("tb_sphericity_momentum_tensor_top OK");
        else
            $display("tb_sphericity_momentum_tensor_top NOT OK");
        $finish;
    end

endmodule
